// ===== sv/nhc_pkg.sv =====
// Shared types and constants for the neo-Hookean Cauchy stress block.
// No dependencies; imported by every module of the block.
package nhc_pkg;

  localparam int GRAD_W   = 32;   // Q4.28 gradient entry
  localparam int REG_W    = 32;   // mu / lambda registers
  localparam int OUT_W    = 48;   // Q32.16 stress
  localparam int JQ_W     = 42;   // floored determinant, Q.28
  localparam int D_W      = JQ_W - 1;  // positive divisor magnitude
  localparam int B_W      = 39;   // F*F^T minus identity, Q.28
  localparam int BLO_W    = 20;   // low slice of B for the split multiply
  localparam int FRAC_W   = 28;
  localparam int MANT_W   = 31;   // log mantissa, Q1.30
  localparam int EXP_W    = 7;
  localparam int LN_W     = 35;   // ln(J), Q.28
  localparam int NUM_W    = 72;   // numerator, Q.28
  localparam int A_W      = NUM_W - 1;  // numerator magnitude
  localparam int QUOT_W   = 48;
  localparam int SQ_STEPS = FRAC_W;
  localparam int NORM_STAGES = 3;
  localparam int LN_LAT   = NORM_STAGES + SQ_STEPS + 1;
  localparam int DIV_LAT  = QUOT_W + 1;
  localparam int DEF_QUEUE_DEPTH = 4;

  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [OUT_W-1:0] OUT_POS_LIM = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_NEG_MAG = {1'b1, {(OUT_W-1){1'b0}}};

  typedef logic signed [GRAD_W-1:0] grad_t;
  typedef logic signed [B_W-1:0]    bm_t;

  localparam bm_t ONE_Q28 = bm_t'(64'd268435456);

  typedef enum logic {
    CFG_SHEAR = 1'b0,
    CFG_LAME  = 1'b1
  } cfg_index_t;

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic                    invalid;
    logic signed [JQ_W-1:0]  jq;
    bm_t [5:0]               bm;    // xx yy zz xy xz yz
  } cls_t;

endpackage

// ===== sv/neo_hookean_cauchy_stress.sv =====
// Neo-Hookean Cauchy stress, one 3x3 deformation gradient per transaction.
// Throughput: one transaction per cycle while the output does not stall; the six
// dividers and the log unit are fully pipelined, one quotient bit and one
// squaring per stage. Reset (rst, synchronous) clears all valid state and
// both registers to zero; datapath registers are not reset.
// Depends on nhc_pkg, nhc_front, nhc_fifo, nhc_back.
module neo_hookean_cauchy_stress #(
  parameter int QUEUE_DEPTH = nhc_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  // grad_00 grad_01 grad_02 grad_10 grad_11 grad_12 grad_20 grad_21 grad_22,
  // 32 bits each, grad_00 in bits 31:0
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [287:0]              s_tdata,
  // stress_xx stress_yy stress_zz stress_xy stress_xz stress_yz,
  // 48 bits each, stress_xx in bits 47:0
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [287:0]              m_tdata,
  // invalid_volume in bit 0
  output logic [0:0]                m_tuser,
  input  logic                      cfg_we,
  input  nhc_pkg::cfg_index_t       cfg_index,
  input  logic [nhc_pkg::REG_W-1:0] cfg_data
);
  import nhc_pkg::*;

  logic [REG_W-1:0] shear_modulus;
  logic [REG_W-1:0] lame_lambda;
  grad_t            grad [9];
  logic             f_valid, f_ready;
  cls_t             f_cls;
  logic             q_valid, q_ready;
  cls_t             q_cls;
  logic [5:0][OUT_W-1:0] stress;
  logic             invalid_volume;

  // configuration registers; the user writes them only while the block is idle, not enforced here
  always_ff @(posedge clk) begin
    if (rst) begin
      shear_modulus <= '0;
      lame_lambda   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SHEAR: shear_modulus <= cfg_data;
        CFG_LAME:  lame_lambda   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) grad[i] = $signed(s_tdata[GRAD_W*i +: GRAD_W]);
  end

  // front: determinant, F*F^T - I, volume classification
  nhc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .grad      (grad),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .cls       (f_cls)
  );

  // decouples the front from output backpressure
  nhc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_cls),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_cls)
  );

  // back: ln(J), numerators, divide by J, saturate
  nhc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (q_valid),
    .in_ready       (q_ready),
    .in_cls         (q_cls),
    .shear_modulus  (shear_modulus),
    .lame_lambda    (lame_lambda),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .stress         (stress),
    .invalid_volume (invalid_volume)
  );

  assign m_tdata    = stress;
  assign m_tuser[0] = invalid_volume;

endmodule

// ===== sv/nhc_front.sv =====
// Front pipeline: gradient in, determinant J, F*F^T - I and volume check out.
// Depends on nhc_pkg.
module nhc_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  nhc_pkg::grad_t grad [9],
  output logic           out_valid,
  input  logic           out_ready,
  output nhc_pkg::cls_t  cls
);
  import nhc_pkg::*;

  localparam int BROW [6] = '{0, 1, 2, 0, 0, 1};
  localparam int BCOL [6] = '{0, 1, 2, 1, 2, 2};

  logic [4:0]         vld;
  logic               en;
  grad_t              f1 [9];
  logic signed [63:0] cp [6];
  logic signed [63:0] bp [6][3];
  grad_t              r0_2 [3];
  grad_t              r0_3 [3];
  logic signed [63:0] c3 [3];
  bm_t                bm3 [6];
  logic signed [65:0] bsum [6];
  bm_t                bm_next [6];
  logic signed [64:0] plo4 [3];
  logic signed [63:0] phi4 [3];
  bm_t                bm4 [6];
  logic signed [97:0] jsum;
  logic signed [JQ_W-1:0] jq_next;

  assign en        = !vld[4] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      bsum[k] = bp[k][0] + bp[k][1] + bp[k][2];
      bm_next[k] = bm_t'($signed(bsum[k][65:28]));
      if (k < 3) bm_next[k] = bm_next[k] - ONE_Q28;
    end
    jsum = '0;
    for (int k = 0; k < 3; k++) begin
      jsum = jsum + (phi4[k] <<< 32) + plo4[k];
    end
    jq_next = $signed(jsum[97:56]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1 <= grad;
      // cofactor products of rows 1 and 2
      cp[0] <= f1[4] * f1[8];
      cp[1] <= f1[5] * f1[7];
      cp[2] <= f1[5] * f1[6];
      cp[3] <= f1[3] * f1[8];
      cp[4] <= f1[3] * f1[7];
      cp[5] <= f1[4] * f1[6];
      for (int k = 0; k < 6; k++) begin
        for (int i = 0; i < 3; i++) begin
          bp[k][i] <= f1[BROW[k]*3 + i] * f1[BCOL[k]*3 + i];
        end
      end
      for (int i = 0; i < 3; i++) begin
        r0_2[i] <= f1[i];
        r0_3[i] <= r0_2[i];
      end
      c3[0] <= cp[0] - cp[1];
      c3[1] <= cp[2] - cp[3];
      c3[2] <= cp[4] - cp[5];
      for (int k = 0; k < 6; k++) begin
        bm3[k] <= bm_next[k];
        bm4[k] <= bm3[k];
      end
      // 32 x 64 product split into two halves, recombined next stage
      for (int i = 0; i < 3; i++) begin
        plo4[i] <= r0_3[i] * $signed({1'b0, c3[i][31:0]});
        phi4[i] <= r0_3[i] * $signed(c3[i][63:32]);
      end
      cls.jq      <= jq_next;
      cls.invalid <= jq_next[JQ_W-1] || (jq_next == '0);
      for (int k = 0; k < 6; k++) begin
        cls.bm[k] <= bm4[k];
      end
    end
  end

endmodule

// ===== sv/nhc_fifo.sv =====
// Short queue of classified items between front and back.
// Depends on nhc_pkg.
module nhc_fifo #(
  parameter int DEPTH = nhc_pkg::DEF_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  nhc_pkg::cls_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output nhc_pkg::cls_t out_data
);
  import nhc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cls_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = count != CNT_W'(DEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== sv/nhc_ln.sv =====
// Pipelined natural log of a positive Q.28 value: normalize, square per bit, scale.
// Depends on nhc_pkg.
module nhc_ln (
  input  logic                            clk,
  input  logic                            en,
  input  logic [nhc_pkg::JQ_W-1:0]        jq,
  output logic signed [nhc_pkg::LN_W-1:0] lnj
);
  import nhc_pkg::*;

  localparam int PROD_W = EXP_W + FRAC_W + 31;
  localparam logic [EXP_W-1:0] EXP_TOP = EXP_W'(JQ_W - 1 - FRAC_W);

  logic [JQ_W-1:0]   xa, xb, xc, na, nb;
  logic [5:0]        za, zb, zc, lza, lzb;
  logic [MANT_W-1:0] ms [SQ_STEPS+1];
  logic [FRAC_W-1:0] fs [SQ_STEPS+1];
  logic signed [EXP_W-1:0] es [SQ_STEPS+1];
  logic signed [PROD_W-1:0] prod;

  // leading-zero count, two shift steps per stage
  always_comb begin
    xa = jq;
    za = '0;
    if (xa[JQ_W-1 -: 32] == '0) begin xa = xa << 32; za = za | 6'd32; end
    if (xa[JQ_W-1 -: 16] == '0) begin xa = xa << 16; za = za | 6'd16; end
    xb = na;
    zb = lza;
    if (xb[JQ_W-1 -: 8] == '0) begin xb = xb << 8; zb = zb + 6'd8; end
    if (xb[JQ_W-1 -: 4] == '0) begin xb = xb << 4; zb = zb + 6'd4; end
    xc = nb;
    zc = lzb;
    if (xc[JQ_W-1 -: 2] == '0) begin xc = xc << 2; zc = zc + 6'd2; end
    if (xc[JQ_W-1] == 1'b0) begin xc = xc << 1; zc = zc + 6'd1; end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na    <= xa;
      lza   <= za;
      nb    <= xb;
      lzb   <= zb;
      ms[0] <= xc[JQ_W-1 -: MANT_W];
      fs[0] <= '0;
      es[0] <= $signed(EXP_TOP - {1'b0, zc});
    end
  end

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     sh;
    assign sq = ms[i] * ms[i];
    assign sh = sq[2*MANT_W-1 : MANT_W-1];
    always_ff @(posedge clk) begin
      if (en) begin
        es[i+1] <= es[i];
        if (sh[MANT_W]) begin
          ms[i+1] <= sh[MANT_W:1];
          fs[i+1] <= {fs[i][FRAC_W-2:0], 1'b1};
        end else begin
          ms[i+1] <= sh[MANT_W-1:0];
          fs[i+1] <= {fs[i][FRAC_W-2:0], 1'b0};
        end
      end
    end
  end

  // log2 in Q.28 times ln2 in Q.30, floored back to Q.28
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= $signed({es[SQ_STEPS], fs[SQ_STEPS]}) * $signed({1'b0, LN2_Q30});
    end
  end

  assign lnj = prod[LN_W+29:30];

endmodule

// ===== sv/nhc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Computes floor(a * 2^16 / d) when it fits in 48 bits. Depends on nhc_pkg.
module nhc_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [nhc_pkg::A_W-1:0]      a,
  input  logic [nhc_pkg::D_W-1:0]      d,
  output logic [nhc_pkg::QUOT_W-1:0]   q,
  output logic                         ovf
);
  import nhc_pkg::*;

  localparam int HI_W = A_W - 32;

  logic [D_W-1:0]    rs [QUOT_W+1];
  logic [D_W-1:0]    ds [QUOT_W+1];
  logic [QUOT_W-1:0] ls [QUOT_W+1];
  logic [QUOT_W-1:0] qs [QUOT_W+1];
  logic              os [QUOT_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rs[0] <= D_W'(a[A_W-1:32]);
      ds[0] <= d;
      ls[0] <= {a[31:0], 16'd0};
      qs[0] <= '0;
      os[0] <= {{(D_W-HI_W){1'b0}}, a[A_W-1:32]} >= d;
    end
  end

  for (genvar i = 0; i < QUOT_W; i++) begin : g_step
    logic [D_W:0] t;
    logic         ge;
    logic [D_W:0] diff;
    assign t    = {rs[i], ls[i][QUOT_W-1]};
    assign ge   = t >= {1'b0, ds[i]};
    assign diff = t - {1'b0, ds[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rs[i+1] <= ge ? diff[D_W-1:0] : t[D_W-1:0];
        ds[i+1] <= ds[i];
        ls[i+1] <= {ls[i][QUOT_W-2:0], 1'b0};
        qs[i+1] <= {qs[i][QUOT_W-2:0], ge};
        os[i+1] <= os[i];
      end
    end
  end

  assign q   = qs[QUOT_W];
  assign ovf = os[QUOT_W];

endmodule

// ===== sv/nhc_back.sv =====
// Back pipeline: ln(J), numerators, six dividers and saturation to Q32.16.
// Depends on nhc_pkg, nhc_ln, nhc_div.
module nhc_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  nhc_pkg::cls_t              in_cls,
  input  logic [nhc_pkg::REG_W-1:0]  shear_modulus,
  input  logic [nhc_pkg::REG_W-1:0]  lame_lambda,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [5:0][nhc_pkg::OUT_W-1:0] stress,
  output logic                       invalid_volume
);
  import nhc_pkg::*;

  localparam int TOTAL = LN_LAT + 3 + DIV_LAT + 1;
  localparam int BHI_W = B_W - BLO_W;

  logic [TOTAL-1:0]        vchain;
  logic                    en;
  cls_t                    cls_d [LN_LAT];
  logic signed [LN_W-1:0]  lnj;
  logic signed [REG_W+BLO_W:0]   pmu_lo [6];
  logic signed [REG_W+BHI_W:0]   pmu_hi [6];
  logic signed [REG_W+LN_W:0]    plam;
  logic signed [NUM_W-1:0] nsum [6];
  logic signed [NUM_W-1:0] n2 [6];
  logic [A_W-1:0]          a3 [6];
  logic [5:0]              neg3;
  logic [D_W-1:0]          d1, d2, d3;
  logic                    inv1, inv2, inv3;
  logic [5:0]              sd_neg [DIV_LAT];
  logic                    sd_inv [DIV_LAT];
  logic [QUOT_W-1:0]       q [6];
  logic [5:0]              ovf;
  logic [OUT_W-1:0]        val [6];
  logic [OUT_W-1:0]        mag [6];

  assign en        = !vchain[TOTAL-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vchain[TOTAL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vchain <= '0;
    end else if (en) begin
      vchain <= {vchain[TOTAL-2:0], in_valid};
    end
  end

  nhc_ln u_ln (
    .clk (clk),
    .en  (en),
    .jq  (in_cls.jq),
    .lnj (lnj)
  );

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      nsum[k] = (pmu_hi[k] <<< BLO_W) + pmu_lo[k];
      if (k < 3) nsum[k] = nsum[k] + plam;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls_d[0] <= in_cls;
      for (int i = 1; i < LN_LAT; i++) cls_d[i] <= cls_d[i-1];
      // numerator products, B split in two to keep each multiplier narrow
      for (int k = 0; k < 6; k++) begin
        pmu_lo[k] <= $signed({1'b0, shear_modulus})
                     * $signed({1'b0, cls_d[LN_LAT-1].bm[k][BLO_W-1:0]});
        pmu_hi[k] <= $signed({1'b0, shear_modulus})
                     * $signed(cls_d[LN_LAT-1].bm[k][B_W-1:BLO_W]);
      end
      plam <= $signed({1'b0, lame_lambda}) * lnj;
      d1   <= cls_d[LN_LAT-1].jq[D_W-1:0];
      inv1 <= cls_d[LN_LAT-1].invalid;
      for (int k = 0; k < 6; k++) begin
        n2[k]   <= nsum[k];
        neg3[k] <= n2[k][NUM_W-1];
        a3[k]   <= n2[k][NUM_W-1] ? A_W'(-n2[k]) : n2[k][A_W-1:0];
      end
      d2   <= d1;
      inv2 <= inv1;
      d3   <= d2;
      inv3 <= inv2;
      sd_neg[0] <= neg3;
      sd_inv[0] <= inv3;
      for (int i = 1; i < DIV_LAT; i++) begin
        sd_neg[i] <= sd_neg[i-1];
        sd_inv[i] <= sd_inv[i-1];
      end
    end
  end

  for (genvar k = 0; k < 6; k++) begin : g_div
    nhc_div u_div (
      .clk (clk),
      .en  (en),
      .a   (a3[k]),
      .d   (d3),
      .q   (q[k]),
      .ovf (ovf[k])
    );
  end

  // truncating quotient with sign restored, clamped to 48-bit range
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      if (sd_neg[DIV_LAT-1][k]) begin
        mag[k] = (ovf[k] || q[k] > OUT_NEG_MAG) ? OUT_NEG_MAG : q[k];
        val[k] = -mag[k];
      end else begin
        mag[k] = q[k];
        val[k] = (ovf[k] || q[k] > OUT_POS_LIM) ? OUT_POS_LIM : q[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      invalid_volume <= sd_inv[DIV_LAT-1];
      for (int k = 0; k < 6; k++) begin
        stress[k] <= sd_inv[DIV_LAT-1] ? '0 : val[k];
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench for neo_hookean_cauchy_stress: drives gradients, predicts stress.
// Depends on nhc_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
  import nhc_pkg::*;

  localparam int LATENCY = 91;

  typedef struct {
    logic [47:0] s [6];
    logic        bad;
  } stress_t;

  logic clk;
  logic rst;
  logic s_tvalid, s_tready;
  logic [287:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [287:0] m_tdata;
  logic [0:0] m_tuser;
  logic cfg_we;
  cfg_index_t cfg_index;
  logic [31:0] cfg_data;

  // model copies of the registers
  logic [31:0] mu_q, lam_q;

  stress_t expected_stress [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;   // long hold-off request, picked up by the receiver
  int hold_cnt = 0;   // cycles the receiver must still hold off

  neo_hookean_cauchy_stress uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("%0t: timeout, %0d transactions outstanding", $time, expected_stress.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Natural log of positive Q.28 J, in Q.28.
  function automatic logic signed [63:0] log_q28(logic [63:0] j);
    logic [63:0] m;
    logic [63:0] f;
    int k;
    logic signed [127:0] p;
    f = 0;
    k = 62;
    while (k > 0 && j[k] == 1'b0) k--;
    m = (k >= 30) ? (j >> (k - 30)) : (j << (30 - k));
    for (int i = 0; i < 28; i++) begin
      m = (m * m) >> 30;
      f = f << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        f[0] = 1'b1;
      end
    end
    p = (128'(signed'(k - 28)) <<< 28) + $signed({64'd0, f});
    p = p * 128'sd744261118;
    return 64'(p >>> 30);
  endfunction

  // Full prediction of one transaction.
  function automatic stress_t cauchy_stress(logic [287:0] d);
    stress_t r;
    logic signed [127:0] f [3][3];
    logic signed [127:0] c0, c1, c2, jq, lnj, b, n, q;
    logic [127:0] mag;
    int rr [6] = '{0, 1, 2, 0, 0, 1};
    int cc [6] = '{0, 1, 2, 1, 2, 2};
    for (int i = 0; i < 9; i++)
      f[i / 3][i % 3] = 128'($signed(d[32*i +: 32]));
    c0 = f[1][1] * f[2][2] - f[1][2] * f[2][1];
    c1 = f[1][2] * f[2][0] - f[1][0] * f[2][2];
    c2 = f[1][0] * f[2][1] - f[1][1] * f[2][0];
    jq = (f[0][0] * c0 + f[0][1] * c1 + f[0][2] * c2) >>> 56;
    r.bad = (jq <= 0);
    for (int k = 0; k < 6; k++) r.s[k] = '0;
    if (r.bad) return r;
    lnj = 128'(log_q28(64'(jq)));
    for (int k = 0; k < 6; k++) begin
      b = (f[rr[k]][0] * f[cc[k]][0] + f[rr[k]][1] * f[cc[k]][1]
           + f[rr[k]][2] * f[cc[k]][2]) >>> 28;
      if (rr[k] == cc[k]) b = b - (128'sd1 <<< 28);
      n = $signed({96'd0, mu_q}) * b;
      if (rr[k] == cc[k]) n = n + $signed({96'd0, lam_q}) * lnj;
      mag = (n < 0) ? -n : n;
      mag = (mag << 16) / jq;   // truncating division on magnitude
      if (n < 0) q = (mag > (128'd1 << 47)) ? -(128'sd1 <<< 47) : -$signed(mag);
      else q = (mag > ((128'd1 << 47) - 1)) ? (128'sd1 <<< 47) - 1 : $signed(mag);
      r.s[k] = q[47:0];
    end
    return r;
  endfunction

  // Receiver: random stall, optional long hold-off; checks on accept.
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (rst) m_tready <= 1'b0;
    else if (hold_cnt > 0) begin
      m_tready <= 1'b0;
      hold_cnt = hold_cnt - 1;
    end else m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    stress_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_stress.size() == 0) begin
        $display("%0t: unexpected transaction, expected none actual %h", $time, m_tdata);
        errors++;
      end else begin
        e = expected_stress.pop_front();
        for (int k = 0; k < 6; k++)
          if (m_tdata[48*k +: 48] !== e.s[k]) begin
            $display("%0t: stress %0d expected %h actual %h", $time, k, e.s[k],
                     m_tdata[48*k +: 48]);
            errors++;
          end
        if (m_tuser[0] !== e.bad) begin
          $display("%0t: invalid_volume expected %b actual %b", $time, e.bad, m_tuser[0]);
          errors++;
        end
      end
    end
  end

  // called at a falling edge, returns at a falling edge with tvalid still high
  task automatic send_grad(logic [287:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_stress.push_back(cauchy_stress(d));
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_stress.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  // leaves cfg_we high; the caller drops it
  task automatic write_reg(cfg_index_t idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    if (idx == CFG_SHEAR) mu_q = v;
    else lam_q = v;
  endtask

  task automatic set_params(logic [31:0] mu, logic [31:0] lam);
    drain();
    write_reg(CFG_SHEAR, mu);
    write_reg(CFG_LAME, lam);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [287:0] diag_grad(logic [31:0] a, logic [31:0] b,
                                             logic [31:0] c);
    logic [287:0] d;
    d = '0;
    d[31:0]    = a;
    d[159:128] = b;
    d[287:256] = c;
    return d;
  endfunction

  function automatic logic [31:0] near(logic [31:0] base, int unsigned spread);
    int unsigned r;
    r = $urandom_range(2 * spread);
    return base + r - spread;
  endfunction

  // identity plus a random perturbation on every entry
  function automatic logic [287:0] near_id(int unsigned spread);
    logic [287:0] d;
    for (int i = 0; i < 9; i++)
      d[32*i +: 32] = near((i % 4 == 0) ? 32'h1000_0000 : 32'd0, spread);
    return d;
  endfunction

  function automatic logic [287:0] full_rand_grad();
    logic [287:0] d;
    for (int i = 0; i < 9; i++) d[32*i +: 32] = $urandom();
    return d;
  endfunction

  function automatic logic [287:0] rand_grad();
    int unsigned sel;
    sel = $urandom_range(3);
    case (sel)
      0: return full_rand_grad();
      1: return near_id(32'd1 << 16);
      default: return near_id($urandom_range(32'd1 << 26));
    endcase
  endfunction

  task automatic test_zero_params();
    set_params(32'd0, 32'd0);
    for (int i = 0; i < 20; i++) send_grad(near_id(32'd1 << 24));
    drain();
  endtask

  task automatic test_diagonal();
    set_params(32'd1000000, 32'd2500000);
    for (int i = 0; i < 30; i++)
      send_grad(diag_grad(near(32'h1000_0000, 32'd1 << 26),
                          near(32'h1000_0000, 32'd1 << 26),
                          near(32'h1000_0000, 32'd1 << 26)));
    drain();
  endtask

  task automatic test_invalid_volume();
    set_params(32'd123456, 32'd654321);
    send_grad(diag_grad(32'hF000_0000, 32'h1000_0000, 32'h1000_0000));
    send_grad('0);
    send_grad(diag_grad(32'h1000_0000, 32'h1000_0000, 32'd0));
    // positive determinant too small for Q.28
    send_grad(diag_grad(32'd1024, 32'd1024, 32'd1024));
    for (int i = 0; i < 26; i++) send_grad(full_rand_grad());
    drain();
  endtask

  task automatic test_saturation();
    logic [287:0] d;
    set_params(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_grad(diag_grad(32'd1 << 20, 32'd1 << 20, 32'd1 << 20));
    send_grad(diag_grad(32'd1 << 18, 32'd1 << 20, 32'd1 << 22));
    for (int i = 0; i < 28; i++) begin
      for (int k = 0; k < 9; k++) d[32*k +: 32] = near(32'd0, 32'd1 << 22);
      send_grad(d);
    end
    drain();
  endtask

  task automatic test_extremes();
    set_params(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_grad({9{32'h8000_0000}});
    send_grad({9{32'h7FFF_FFFF}});
    send_grad(diag_grad(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_grad(diag_grad(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_grad(diag_grad(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    for (int i = 0; i < 15; i++) send_grad(full_rand_grad());
    drain();
  endtask

  task automatic test_random_traffic(int s_pct, int r_pct, int n);
    set_params($urandom(), $urandom());
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) send_grad(rand_grad());
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    set_params($urandom(), $urandom());
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    hold_req = 300;
    @(negedge clk);
    for (int i = 0; i < 150; i++) send_grad(rand_grad());
    drain();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_SHEAR;
    cfg_data = '0;
    mu_q = '0;
    lam_q = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_zero_params();
    test_diagonal();
    test_invalid_volume();
    test_saturation();
    test_extremes();
    test_random_traffic(11, 82, 230);
    test_random_traffic(82, 11, 230);
    test_random_traffic(0, 0, 230);
    test_backpressure();
    drain();
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
